// ===== rtl/abae_pkg.sv =====
// Shared types and constants of the adaptive binary arithmetic encoder.
package abae_pkg;

    localparam int PROB_W   = 12;
    localparam int CTX_W    = 9;
    localparam int BOUND_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [PROB_W-1:0] PROB_INIT = 12'd2048;
    localparam logic [PROB_W-1:0] PROB_MAX  = 12'hfff;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CONTEXT = 1'b1;

    localparam logic [1:0] MODE_SINGLE       = 2'd0;
    localparam logic [1:0] MODE_TREE9        = 2'd1;
    localparam logic [1:0] MODE_TREE8_PREFIX = 2'd2;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic index;
        logic mult;
        logic update;
        logic emit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic match;
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/abae_in_if.sv =====
// Input channel: one encode or flush item per beat.
interface abae_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic       bit_req;
    logic [7:0] prefix;

    modport source (output valid, output op, output bit_req, output prefix, input ready);
    modport sink   (input valid, input op, input bit_req, input prefix, output ready);
endinterface

// ===== rtl/abae_out_if.sv =====
// Output channel: one compressed byte per beat.
interface abae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/abae_dp.sv =====
// Datapath: bounds, context, probability memory, multiplier and output register.
module abae_dp #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  abae_pkg::t_cmd                   i_cmd,
    output abae_pkg::t_stat                  o_stat,
    input  logic                             i_op,
    input  logic                             i_bit_req,
    input  logic [7:0]                       i_prefix,
    input  logic                             i_cfg_we,
    input  logic [abae_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [abae_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_out_last
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int REM_W = 24;
    localparam int QSTEPS = 8;

    logic [abae_pkg::PROB_W-1:0] r_mem [TABLE_DEPTH];
    logic [abae_pkg::PROB_W-1:0] r_rdata;

    logic [1:0]                     r_mode;
    logic [abae_pkg::CTX_W-1:0]     r_ctx;
    logic [abae_pkg::BOUND_W-1:0]   r_low, r_high, r_prod;
    logic                           r_op, r_bit;
    logic [7:0]                     r_prefix;
    logic [AW-1:0]                  r_addr, r_clr_cnt;
    logic [1:0]                     r_n;
    logic                           r_out_valid, r_out_last;
    logic [7:0]                     r_out_byte;

    logic [AW-1:0]                  n_addr;
    logic [abae_pkg::PROB_W-1:0]    n_prob;
    logic [abae_pkg::CTX_W-1:0]     n_ctx;
    logic [abae_pkg::BOUND_W-1:0]   n_prod, n_mid;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [abae_pkg::PROB_W-1:0]    mem_wdata;
    logic                           emit_last;

    // table index reduced modulo the depth by conditional subtraction
    always_comb begin
        logic [REM_W-1:0] v_rem;
        logic [REM_W-1:0] v_sub;
        v_rem = {15'd0, r_ctx};
        if (r_mode == abae_pkg::MODE_TREE8_PREFIX) begin
            v_rem = v_rem | {8'd0, r_prefix, 8'd0};
        end
        for (int k = QSTEPS - 1; k >= 0; k--) begin
            v_sub = REM_W'(TABLE_DEPTH) << k;
            if (v_rem >= v_sub) begin
                v_rem = v_rem - v_sub;
            end
        end
        n_addr = v_rem[AW-1:0];
    end

    always_comb begin
        logic [19:0] v_rng;
        v_rng  = 20'((r_high - r_low) >> 12);
        n_prod = {12'd0, v_rng} * {20'd0, r_rdata};
        if (r_bit) begin
            n_prob = r_rdata + ((abae_pkg::PROB_MAX - r_rdata) >> 4);
        end else begin
            n_prob = r_rdata - (r_rdata >> 4);
        end
        n_mid = r_low + r_prod;
    end

    always_comb begin
        logic [abae_pkg::CTX_W:0] v_nc;
        v_nc = {r_ctx, r_bit};
        if (r_mode == abae_pkg::MODE_SINGLE) begin
            n_ctx = {8'd0, r_bit};
        end else if (r_mode == abae_pkg::MODE_TREE8_PREFIX) begin
            n_ctx = (v_nc >= 10'd256) ? 9'd1 : v_nc[abae_pkg::CTX_W-1:0];
        end else begin
            n_ctx = v_nc[abae_pkg::CTX_W] ? 9'd1 : v_nc[abae_pkg::CTX_W-1:0];
        end
    end

    always_comb begin
        mem_we    = i_cmd.clear | i_cmd.mult;
        mem_waddr = i_cmd.clear ? r_clr_cnt : r_addr;
        mem_wdata = i_cmd.clear ? abae_pkg::PROB_INIT : n_prob;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[n_addr];
    end

    assign emit_last = (r_n == 2'd3) || ((r_low[23:16] ^ r_high[23:16]) != 8'd0);

    always_comb begin
        o_stat.clear_last = (r_clr_cnt == AW'(TABLE_DEPTH - 1));
        o_stat.match      = ((r_low[31:24] ^ r_high[31:24]) == 8'd0);
        o_stat.last       = (r_op == abae_pkg::OP_FLUSH) ? (r_n == 2'd3) : emit_last;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= abae_pkg::MODE_TREE9;
            r_ctx       <= '0;
            r_low       <= '0;
            r_high      <= '1;
            r_clr_cnt   <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    abae_pkg::CFG_CONTEXT_MODE:    r_mode <= i_cfg_data[1:0];
                    abae_pkg::CFG_INITIAL_CONTEXT: r_ctx  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.load) begin
                r_n <= '0;
            end
            if (i_cmd.mult) begin
                r_ctx <= n_ctx;
            end
            if (i_cmd.update) begin
                if (r_bit) begin
                    r_high <= n_mid;
                end else begin
                    r_low <= n_mid + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_low  <= {r_low[23:0], 8'd0};
                r_high <= {r_high[23:0], 8'hff};
                r_n    <= r_n + 1'b1;
            end
            if (i_cmd.flush) begin
                r_high <= {r_high[23:0], 8'd0};
                r_n    <= r_n + 1'b1;
            end
            if (i_cmd.emit || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_bit    <= i_bit_req;
            r_prefix <= i_prefix;
        end
        if (i_cmd.index) begin
            r_addr <= n_addr;
        end
        if (i_cmd.mult) begin
            r_prod <= n_prod;
        end
        if (i_cmd.emit || i_cmd.flush) begin
            r_out_byte <= r_high[31:24];
            r_out_last <= o_stat.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/abae_ctrl.sv =====
// Controller: clearing pass, item sequencing and byte emission.
module abae_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    input  abae_pkg::t_stat i_stat,
    output abae_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_INDEX  = 7'b0000100,
        S_MULT   = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_FLUSH  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_in_op == abae_pkg::OP_FLUSH) ? S_FLUSH : S_INDEX;
                end
            end
            S_INDEX: begin
                o_cmd.index = 1'b1;
                n_state = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.match) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    if (i_stat.last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/adaptive_binary_arith_encoder_core.sv =====
// Top level of the adaptive binary arithmetic encoder.
// Encode beat: index, multiply and update steps, then up to four bytes while the top bytes of low and high match.
// Flush beat: four bytes, one byte per cycle while the output accepts them.
// A new beat is taken only in the idle state, once the previous item is done; a busy output stalls emission.
// Reset (synchronous, active low) starts a clearing pass over all TABLE_DEPTH entries that
// sets every probability to 2048; no beat is accepted meanwhile, configuration writes are.
module adaptive_binary_arith_encoder_core #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    abae_in_if.sink                          i_in,
    abae_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [abae_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [abae_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    abae_pkg::t_cmd  cmd;
    abae_pkg::t_stat stat;
    logic            in_ready;

    abae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    abae_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_in.op),
        .i_bit_req   (i_in.bit_req),
        .i_prefix    (i_in.prefix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule
